FILE: src/instruction_class_decoder_assert.svh
// ----------------------------------------------------------------------------
// instruction class decoder assertion macros
// clocked property checks with a reset that masks them
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_CLASS_DECODER_ASSERT_SVH
`define INSTRUCTION_CLASS_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

`define ICD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ICD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ICD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define ICD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/icd_pkg.sv
// ----------------------------------------------------------------------------
// icd_pkg
// class codes, halfword kinds and the decoded result word shared by the
// instruction class decoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package icd_pkg;

  typedef enum logic [3:0] {
    CL_UNDEF  = 4'd0,
    CL_MUL    = 4'd1,
    CL_MULL   = 4'd2,
    CL_BX     = 4'd3,
    CL_SWP    = 4'd4,
    CL_HALF   = 4'd5,
    CL_SINGLE = 4'd6,
    CL_DP     = 4'd7,
    CL_BLOCK  = 4'd8,
    CL_BRANCH = 4'd9,
    CL_CPXFER = 4'd10,
    CL_CDP    = 4'd11,
    CL_CPREG  = 4'd12,
    CL_SWI    = 4'd13
  } insn_class_t;

  localparam logic [1:0] HW_UNSIGNED_HALF = 2'd0;
  localparam logic [1:0] HW_SIGNED_BYTE   = 2'd1;
  localparam logic [1:0] HW_SIGNED_HALF   = 2'd2;

  // opcode bits 24..23 of tst, teq, cmp, cmn
  localparam logic [1:0] OP_COMPARE_HI = 2'b10;

  typedef struct packed {
    insn_class_t insn_class;
    logic [3:0]  alu_op;
    logic        set_flags;
    logic        accumulate;
    logic        signed_or_link;
    logic        load_dir;
    logic        writeback;
    logic        byte_access;
    logic        up_dir;
    logic        pre_index;
    logic        immediate;
    logic [1:0]  halfword_kind;
  } icd_result_t;

endpackage

`default_nettype wire

FILE: src/icd_decode.sv
// ----------------------------------------------------------------------------
// icd_decode
// combinational class and modifier decode from instruction bits 27..20
// and 7..4
// ----------------------------------------------------------------------------
`default_nettype none

module icd_decode (
  input  wire logic [7:0]          hi,
  input  wire logic [3:0]          lo,
  output icd_pkg::icd_result_t     result
);
  import icd_pkg::*;

  logic [2:0]  top;
  logic [1:0]  sh;
  logic [3:0]  op;
  insn_class_t cls;

  assign top = hi[7:5];
  assign sh  = lo[2:1];
  assign op  = hi[4:1];

  always_comb begin
    cls = CL_UNDEF;
    if (top == 3'd0 && lo[0] && lo[3]) begin
      if (sh == 2'd0) begin
        if (hi[7:2] == 6'd0) begin
          cls = CL_MUL;
        end else if (hi[7:3] == 5'b00001) begin
          cls = CL_MULL;
        end else if (hi[7:3] == 5'b00010 && hi[1:0] == 2'b00) begin
          cls = CL_SWP;
        end
      end else if (hi[0] || sh == 2'd1) begin
        cls = CL_HALF;
      end
    end else if (hi == 8'h12 && lo == 4'h1) begin
      cls = CL_BX;
    end else if (top[2:1] == 2'b00) begin
      if (!(op[3:2] == OP_COMPARE_HI && !hi[0])) begin
        cls = CL_DP;
      end
    end else if (top[2:1] == 2'b01) begin
      cls = CL_SINGLE;
    end else if (top == 3'd4) begin
      if (!hi[2]) begin
        cls = CL_BLOCK;
      end
    end else if (top == 3'd5) begin
      cls = CL_BRANCH;
    end else if (top == 3'd6) begin
      cls = CL_CPXFER;
    end else if (hi[4]) begin
      cls = CL_SWI;
    end else if (lo[0]) begin
      cls = CL_CPREG;
    end else begin
      cls = CL_CDP;
    end
  end

  always_comb begin
    result            = '0;
    result.insn_class = cls;
    case (cls)
      CL_MUL: begin
        result.set_flags  = hi[0];
        result.accumulate = hi[1];
      end
      CL_MULL: begin
        result.set_flags      = hi[0];
        result.accumulate     = hi[1];
        result.signed_or_link = hi[2];
      end
      CL_SWP: begin
        result.byte_access = hi[2];
      end
      CL_HALF: begin
        result.load_dir  = hi[0];
        result.writeback = hi[1];
        result.up_dir    = hi[3];
        result.pre_index = hi[4];
        result.immediate = hi[2];
        case (sh)
          2'd2:    result.halfword_kind = HW_SIGNED_BYTE;
          2'd3:    result.halfword_kind = HW_SIGNED_HALF;
          default: result.halfword_kind = HW_UNSIGNED_HALF;
        endcase
      end
      CL_SINGLE: begin
        result.load_dir    = hi[0];
        result.writeback   = hi[1];
        result.byte_access = hi[2];
        result.up_dir      = hi[3];
        result.pre_index   = hi[4];
        result.immediate   = hi[5];
      end
      CL_DP: begin
        result.alu_op    = op;
        result.set_flags = (op[3:2] == OP_COMPARE_HI) ? 1'b0 : hi[0];
        result.immediate = hi[5];
      end
      CL_BLOCK: begin
        result.load_dir  = hi[0];
        result.writeback = hi[1];
        result.up_dir    = hi[3];
        result.pre_index = hi[4];
      end
      CL_BRANCH: begin
        result.signed_or_link = hi[4];
      end
      CL_CPXFER, CL_CPREG: begin
        result.load_dir = hi[0];
      end
      default: begin
        result.insn_class = cls;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/instruction_class_decoder.sv
// ----------------------------------------------------------------------------
// instruction_class_decoder
// instruction class and modifier decode with registered input and output
// ----------------------------------------------------------------------------
// Each instruction word passes an input register and then a result register
// before its result appears on the output, and a new word is accepted every
// cycle while the output is taken.
// The decode between the two registers looks only at bits 27..20 and 7..4;
// the other bits of the word are ignored. When the output is stalled, one
// further word is held in the input register before the input stalls.
`default_nettype none

`include "instruction_class_decoder_assert.svh"

module instruction_class_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] instruction_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       insn_class,
  output logic [3:0]       alu_op,
  output logic             set_flags,
  output logic             accumulate,
  output logic             signed_or_link,
  output logic             load_dir,
  output logic             writeback,
  output logic             byte_access,
  output logic             up_dir,
  output logic             pre_index,
  output logic             immediate,
  output logic [1:0]       halfword_kind
);
  import icd_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_hi;
  logic [3:0]  s1_lo;
  logic        s2_free;
  logic        s1_free;
  icd_result_t dec_result;
  icd_result_t result;

  assign s2_free  = !out_valid || !out_stall;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_hi <= instruction_word[27:20];
      s1_lo <= instruction_word[7:4];
    end
  end

  icd_decode u_decode (
    .hi     (s1_hi),
    .lo     (s1_lo),
    .result (dec_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      result <= dec_result;
    end
  end

  assign insn_class     = 4'(result.insn_class);
  assign alu_op         = result.alu_op;
  assign set_flags      = result.set_flags;
  assign accumulate     = result.accumulate;
  assign signed_or_link = result.signed_or_link;
  assign load_dir       = result.load_dir;
  assign writeback      = result.writeback;
  assign byte_access    = result.byte_access;
  assign up_dir         = result.up_dir;
  assign pre_index      = result.pre_index;
  assign immediate      = result.immediate;
  assign halfword_kind  = result.halfword_kind;

  `ICD_ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && !in_stall, s1_valid,
    "accepted word lost")

  `ICD_ASSERT_SAME(a_undef_clear, clk, rst, out_valid && insn_class == 4'(CL_UNDEF),
    alu_op == 4'd0 && set_flags == 1'b0 && load_dir == 1'b0 && immediate == 1'b0
    && halfword_kind == 2'd0, "undefined class with modifiers")

  `ICD_ASSERT_SAME(a_alu_op_dp, clk, rst, out_valid && alu_op != 4'd0,
    insn_class == 4'(CL_DP), "alu opcode outside data processing")

  `ICD_ASSERT_SAME(a_hw_kind, clk, rst, out_valid && halfword_kind != 2'd0,
    insn_class == 4'(CL_HALF) && halfword_kind != 2'd3, "bad halfword kind")

endmodule

`default_nettype wire
